### src/dtld_pkg.sv
`default_nettype none
package dtld_pkg;

  localparam int MAX_LINE_CAPACITY = 4096;
  localparam int CAP_W             = 13;
  localparam int LIMIT_W           = 32;
  localparam int TOTAL_W           = 33;
  localparam int CFG_ADDR_W        = 2;
  localparam int CFG_DATA_W        = 32;
  localparam int MAX_RES           = 3;
  localparam int RES_IDX_W         = 2;
  localparam int QDEPTH            = 2;
  localparam int QPTR_W            = $clog2(QDEPTH);
  localparam int QCNT_W            = $clog2(QDEPTH + 1);

  localparam logic [CAP_W-1:0]   MAX_CAP       = CAP_W'(MAX_LINE_CAPACITY);
  localparam logic [CAP_W-1:0]   CAP_RESET     = 13'd4096;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 32'd1048576;
  localparam logic [TOTAL_W-1:0] TOTAL_TOP     = {TOTAL_W{1'b1}};

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_DOT = 8'h2E;

  localparam logic [CFG_ADDR_W-1:0] REG_LINE_CAPACITY  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RESPONSE_LIMIT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_UNSTUFF_ENABLE = 2'd2;

  typedef enum logic [1:0] {
    MODE_DATA = 2'd0,
    MODE_END  = 2'd1,
    MODE_FAIL = 2'd2,
    MODE_RSVD = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IN_LINE   = 3'd0,
    ST_LINE_DONE = 3'd1,
    ST_TERM      = 3'd2,
    ST_ENDED     = 3'd3,
    ST_CEILING   = 3'd4,
    ST_FAILED    = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    PH_OPEN    = 5'b00001,
    PH_TERM    = 5'b00010,
    PH_ENDED   = 5'b00100,
    PH_CEILING = 5'b01000,
    PH_FAILED  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    status_t    status;
  } res_t;

  typedef struct packed {
    logic [RES_IDX_W-1:0] cnt_m1;
    logic                 trunc;
    res_t [MAX_RES-1:0]   res;
  } bundle_t;

  function automatic status_t phase_status(phase_t ph);
    status_t s;
    unique case (ph)
      PH_TERM:    s = ST_TERM;
      PH_ENDED:   s = ST_ENDED;
      PH_CEILING: s = ST_CEILING;
      PH_FAILED:  s = ST_FAILED;
      default:    s = ST_IN_LINE;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

### src/dtld_front.sv
`default_nettype none
module dtld_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [dtld_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [dtld_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [7:0]                         in_tdata,
  input  wire logic [1:0]                         in_tuser,
  input  wire logic                               q_full,
  output logic                                    q_push,
  output dtld_pkg::bundle_t                       q_wdata
);
  import dtld_pkg::*;

  logic [CAP_W-1:0]   cap_r;
  logic [LIMIT_W-1:0] limit_r;
  logic               unstuff_r;

  logic               hp_r, hp_nxt;
  logic               hr_r, hr_nxt;
  logic [CAP_W-1:0]   kept_r, kept_nxt;
  logic               begun_r, begun_nxt;
  logic               ovf_r, ovf_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               trunc_r, trunc_nxt;
  phase_t             ph_r, ph_nxt;

  logic               accept;
  logic [CAP_W-1:0]   eff_cap;
  logic [RES_IDX_W-1:0] k;
  res_t [MAX_RES-1:0] res;
  mode_t              mode;
  logic [7:0]         c;

  assign mode      = mode_t'(in_tuser);
  assign c         = in_tdata;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CAP_W'(1);
    end else if (cap_r > MAX_CAP) begin
      eff_cap = MAX_CAP;
    end else begin
      eff_cap = cap_r;
    end
  end

  always_comb begin
    hp_nxt    = hp_r;
    hr_nxt    = hr_r;
    kept_nxt  = kept_r;
    begun_nxt = begun_r;
    ovf_nxt   = ovf_r;
    total_nxt = total_r;
    trunc_nxt = trunc_r;
    ph_nxt    = ph_r;
    k         = '0;
    res       = '0;
    if (ph_r != PH_OPEN) begin
      res[k] = '{data: 8'h00, valid: 1'b0, status: phase_status(ph_r)};
      k = k + 1'b1;
    end else begin
      unique case (mode)
        MODE_DATA: begin
          if (total_r != TOTAL_TOP) begin
            total_nxt = total_r + 1'b1;
          end
          begun_nxt = 1'b1;
          if (c == CH_LF) begin
            if (ovf_r) begin
              trunc_nxt = 1'b1;
            end
            if (hp_r) begin
              ph_nxt = PH_TERM;
              res[k] = '{data: 8'h00, valid: 1'b0, status: ST_TERM};
            end else begin
              res[k] = '{data: 8'h00, valid: 1'b0, status: ST_LINE_DONE};
            end
            k = k + 1'b1;
            hp_nxt    = 1'b0;
            hr_nxt    = 1'b0;
            kept_nxt  = '0;
            begun_nxt = 1'b0;
            ovf_nxt   = 1'b0;
          end else begin
            if ((kept_r + 1'b1) < eff_cap) begin
              kept_nxt = kept_r + 1'b1;
              if (kept_r == '0 && c == CH_DOT) begin
                hp_nxt = 1'b1;
              end else if (hp_r && !hr_r && c == CH_DOT && unstuff_r) begin
                hp_nxt = 1'b0;
                res[k] = '{data: CH_DOT, valid: 1'b1, status: ST_IN_LINE};
                k = k + 1'b1;
              end else if (hp_r && !hr_r && c == CH_CR) begin
                hr_nxt = 1'b1;
              end else begin
                if (hp_r) begin
                  hp_nxt = 1'b0;
                  res[k] = '{data: CH_DOT, valid: 1'b1, status: ST_IN_LINE};
                  k = k + 1'b1;
                end
                if (hr_r) begin
                  hr_nxt = 1'b0;
                  res[k] = '{data: CH_CR, valid: 1'b1, status: ST_IN_LINE};
                  k = k + 1'b1;
                end
                if (c == CH_CR) begin
                  hr_nxt = 1'b1;
                end else begin
                  res[k] = '{data: c, valid: 1'b1, status: ST_IN_LINE};
                  k = k + 1'b1;
                end
              end
            end else begin
              ovf_nxt = 1'b1;
            end
            // ceiling: flush whatever is held, raw
            if (total_nxt > {1'b0, limit_r}) begin
              trunc_nxt = 1'b1;
              ph_nxt    = PH_CEILING;
              if (hp_nxt) begin
                res[k] = '{data: CH_DOT, valid: 1'b1, status: ST_IN_LINE};
                k = k + 1'b1;
              end
              if (hr_nxt) begin
                res[k] = '{data: CH_CR, valid: 1'b1, status: ST_IN_LINE};
                k = k + 1'b1;
              end
              if (k != '0) begin
                res[k - 1'b1].status = ST_CEILING;
              end else begin
                res[k] = '{data: 8'h00, valid: 1'b0, status: ST_CEILING};
                k = k + 1'b1;
              end
              hp_nxt    = 1'b0;
              hr_nxt    = 1'b0;
              kept_nxt  = '0;
              begun_nxt = 1'b0;
              ovf_nxt   = 1'b0;
            end
          end
        end
        MODE_END: begin
          if (begun_r) begin
            if (ovf_r) begin
              trunc_nxt = 1'b1;
            end
            if (hp_r) begin
              ph_nxt = PH_TERM;
              res[k] = '{data: 8'h00, valid: 1'b0, status: ST_TERM};
            end else begin
              res[k] = '{data: 8'h00, valid: 1'b0, status: ST_LINE_DONE};
            end
            k = k + 1'b1;
          end
          if (!(begun_r && hp_r)) begin
            ph_nxt = PH_ENDED;
            res[k] = '{data: 8'h00, valid: 1'b0, status: ST_ENDED};
            k = k + 1'b1;
          end
          hp_nxt    = 1'b0;
          hr_nxt    = 1'b0;
          kept_nxt  = '0;
          begun_nxt = 1'b0;
          ovf_nxt   = 1'b0;
        end
        MODE_FAIL: begin
          hp_nxt    = 1'b0;
          hr_nxt    = 1'b0;
          kept_nxt  = '0;
          begun_nxt = 1'b0;
          ovf_nxt   = 1'b0;
          ph_nxt    = PH_FAILED;
          res[k] = '{data: 8'h00, valid: 1'b0, status: ST_FAILED};
          k = k + 1'b1;
        end
        MODE_RSVD: begin
        end
      endcase
    end
  end

  assign q_push  = accept && (k != '0);
  assign q_wdata = '{cnt_m1: k - 1'b1, trunc: trunc_nxt, res: res};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CAP_RESET;
      limit_r   <= LIMIT_RESET;
      unstuff_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LINE_CAPACITY:  cap_r     <= cfg_wdata[CAP_W-1:0];
        REG_RESPONSE_LIMIT: limit_r   <= cfg_wdata[LIMIT_W-1:0];
        REG_UNSTUFF_ENABLE: unstuff_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r    <= 1'b0;
      hr_r    <= 1'b0;
      kept_r  <= '0;
      begun_r <= 1'b0;
      ovf_r   <= 1'b0;
      total_r <= '0;
      trunc_r <= 1'b0;
      ph_r    <= PH_OPEN;
    end else if (accept) begin
      hp_r    <= hp_nxt;
      hr_r    <= hr_nxt;
      kept_r  <= kept_nxt;
      begun_r <= begun_nxt;
      ovf_r   <= ovf_nxt;
      total_r <= total_nxt;
      trunc_r <= trunc_nxt;
      ph_r    <= ph_nxt;
    end
  end

  a_closed_single: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ph_r != PH_OPEN) |-> (q_push && q_wdata.cnt_m1 == '0))
    else $error("closed stream item must give one result");

  a_trunc_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(trunc_r) |-> trunc_r)
    else $error("truncated flag cleared");

  a_closed_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ph_r != PH_OPEN) |=> ($stable(total_r) && $stable(ph_r)))
    else $error("closed stream changed state");

endmodule
`default_nettype wire

### src/dtld_queue.sv
`default_nettype none
module dtld_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire dtld_pkg::bundle_t wdata,
  output logic                   full,
  output logic                   nonempty,
  input  wire logic              pop,
  output dtld_pkg::bundle_t      rdata
);
  import dtld_pkg::*;

  bundle_t             q_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_r, wr_nxt;
  logic [QPTR_W-1:0]   rd_r, rd_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign nonempty = (cnt_r != '0);
  assign rdata    = q_r[rd_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count overflow");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == QCNT_W'(QDEPTH)) |-> (wr_r == rd_r))
    else $error("queue pointers out of step");

endmodule
`default_nettype wire

### src/dtld_back.sv
`default_nettype none
module dtld_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_nonempty,
  input  wire dtld_pkg::bundle_t q_rdata,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [7:0]             out_tdata,
  output logic [4:0]             out_tuser,
  output logic                   out_tlast
);
  import dtld_pkg::*;

  logic [RES_IDX_W-1:0] idx_r, idx_nxt;
  res_t                 cur;
  logic                 fire;

  assign cur        = q_rdata.res[idx_r];
  assign out_tvalid = q_nonempty;
  assign out_tdata  = cur.data;
  assign out_tuser  = {q_rdata.trunc, cur.status, cur.valid};
  assign out_tlast  = (idx_r == q_rdata.cnt_m1);
  assign fire       = out_tvalid && out_tready;
  assign q_pop      = fire && out_tlast;

  always_comb begin
    idx_nxt = idx_r;
    if (fire) begin
      idx_nxt = out_tlast ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    q_nonempty |-> (idx_r <= q_rdata.cnt_m1))
    else $error("result index past bundle");

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !q_nonempty |-> (idx_r == '0))
    else $error("result index not cleared");

endmodule
`default_nettype wire

### src/dot_terminated_line_deframer_top.sv
// channel | dir | tdata                  | tuser                                  | tlast
// in      | in  | [7:0] data_byte        | [1:0] mode                             | -
// out     | out | [7:0] out_byte         | [0] byte_valid [3:1] status [4] trunc  | last
// cfg     | in  | cfg_addr = reg index, cfg_wdata = value, written when cfg_we is high
//
// One input item accepted per cycle while the two-entry result queue has room.
// Each item yields 0 to 3 results, sent one per cycle; the output port sets the rate.
// Each item's results are held in the result queue before they reach the output.
// rst_n is synchronous, active low; registers return to their reset values.
// Input and output stall independently through the queue.
`default_nettype none
module dot_terminated_line_deframer_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [dtld_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [dtld_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [7:0]                      in_tdata,   // [7:0] data_byte
  input  wire logic [1:0]                      in_tuser,   // [1:0] mode
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [7:0]                           out_tdata,  // [7:0] out_byte
  output logic [4:0]                           out_tuser,  // [0] byte_valid [3:1] status [4] truncated
  output logic                                 out_tlast
);
  import dtld_pkg::*;

  logic    q_push, q_full, q_nonempty, q_pop;
  bundle_t q_wdata, q_rdata;

  dtld_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  dtld_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .nonempty (q_nonempty),
    .pop      (q_pop),
    .rdata    (q_rdata)
  );

  dtld_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

### bench/dot_terminated_line_deframer_top_tb.sv
`timescale 1ns / 1ps
import dtld_pkg::*;

typedef struct packed {
  logic [7:0] data;
  logic       valid;
  status_t    status;
  logic       trunc;
  logic       last;
} line_result_t;

typedef struct {
  bit              held_period;
  bit              held_return;
  int unsigned     kept;
  bit              line_begun;
  bit              line_overflowed;
  longint unsigned total;
  bit              trunc;
  status_t         phase;
} deframe_state_t;

class line_scoreboard;
  deframe_state_t  st;
  int unsigned     line_capacity = 4096;
  longint unsigned response_limit = 1048576;
  bit              unstuff = 1'b1;
  line_result_t    pend[$];
  line_result_t    awaited[$];
  int              mismatches;
  int              results_seen;
  int              items_seen;

  function new();
    clear_line();
    st.total = 0;
    st.trunc = 1'b0;
    st.phase = ST_IN_LINE;
  endfunction

  function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_LINE_CAPACITY:  line_capacity = v[CAP_W-1:0];
      REG_RESPONSE_LIMIT: response_limit = v;
      REG_UNSTUFF_ENABLE: unstuff = v[0];
      default: ;
    endcase
  endfunction

  function void emit(logic [7:0] d, logic v, status_t s);
    line_result_t r;
    r.data   = v ? d : 8'h00;
    r.valid  = v;
    r.status = s;
    r.trunc  = 1'b0;
    r.last   = 1'b0;
    pend.push_back(r);
  endfunction

  function void clear_line();
    st.held_period     = 1'b0;
    st.held_return     = 1'b0;
    st.kept            = 0;
    st.line_begun      = 1'b0;
    st.line_overflowed = 1'b0;
  endfunction

  function void end_line();
    if (st.line_overflowed) st.trunc = 1'b1;
    if (st.held_period) begin
      st.phase = ST_TERM;
      emit(8'h00, 1'b0, ST_TERM);
    end else begin
      emit(8'h00, 1'b0, ST_LINE_DONE);
    end
    clear_line();
  endfunction

  // results of one item go to pend; state advances in st
  function void step(mode_t m, logic [7:0] c);
    int unsigned cap;
    int unsigned prior;
    pend.delete();
    if (st.phase != ST_IN_LINE) begin
      emit(8'h00, 1'b0, st.phase);
    end else if (m == MODE_DATA) begin
      if (st.total < longint'(TOTAL_TOP)) st.total++;
      st.line_begun = 1'b1;
      if (c == CH_LF) begin
        end_line();
      end else begin
        cap = line_capacity;
        if (cap < 1) cap = 1;
        if (cap > MAX_LINE_CAPACITY) cap = MAX_LINE_CAPACITY;
        if (st.kept + 1 < cap) begin
          prior = st.kept;
          st.kept++;
          if (prior == 0 && c == CH_DOT) begin
            st.held_period = 1'b1;
          end else if (st.held_period && !st.held_return && c == CH_DOT && unstuff) begin
            st.held_period = 1'b0;
            emit(CH_DOT, 1'b1, ST_IN_LINE);
          end else if (st.held_period && !st.held_return && c == CH_CR) begin
            st.held_return = 1'b1;
          end else begin
            if (st.held_period) begin
              st.held_period = 1'b0;
              emit(CH_DOT, 1'b1, ST_IN_LINE);
            end
            if (st.held_return) begin
              st.held_return = 1'b0;
              emit(CH_CR, 1'b1, ST_IN_LINE);
            end
            if (c == CH_CR) st.held_return = 1'b1;
            else emit(c, 1'b1, ST_IN_LINE);
          end
        end else begin
          st.line_overflowed = 1'b1;
        end
        if (st.total > response_limit) begin
          st.trunc = 1'b1;
          st.phase = ST_CEILING;
          if (st.held_period) emit(CH_DOT, 1'b1, ST_IN_LINE);
          if (st.held_return) emit(CH_CR, 1'b1, ST_IN_LINE);
          if (pend.size() > 0) pend[pend.size()-1].status = ST_CEILING;
          else emit(8'h00, 1'b0, ST_CEILING);
          clear_line();
        end
      end
    end else if (m == MODE_END) begin
      if (st.line_begun) end_line();
      if (st.phase == ST_IN_LINE) begin
        st.phase = ST_ENDED;
        emit(8'h00, 1'b0, ST_ENDED);
      end
    end else if (m == MODE_FAIL) begin
      clear_line();
      st.phase = ST_FAILED;
      emit(8'h00, 1'b0, ST_FAILED);
    end
    foreach (pend[i]) begin
      pend[i].trunc = st.trunc;
      pend[i].last  = (i == pend.size() - 1);
    end
  endfunction

  function bit would_close(mode_t m, logic [7:0] c);
    deframe_state_t saved;
    bit closes;
    saved = st;
    step(m, c);
    closes = (st.phase != ST_IN_LINE);
    st = saved;
    pend.delete();
    return closes;
  endfunction

  function void note_item(mode_t m, logic [7:0] c);
    step(m, c);
    foreach (pend[i]) awaited.push_back(pend[i]);
    items_seen++;
  endfunction

  function void check_result(logic [7:0] d, logic [4:0] u, logic l);
    line_result_t e;
    results_seen++;
    if (awaited.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: byte %h user %h last %b", d, u, l);
      return;
    end
    e = awaited.pop_front();
    if (d !== e.data || u[0] !== e.valid || u[3:1] !== e.status ||
        u[4] !== e.trunc || l !== e.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: exp byte %h valid %b status %0d trunc %b last %b, got byte %h valid %b status %0d trunc %b last %b",
                 results_seen, e.data, e.valid, e.status, e.trunc, e.last,
                 d, u[0], u[3:1], u[4], l);
    end
  endfunction
endclass

module dot_terminated_line_deframer_top_tb;
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;   // [7:0] data_byte
  logic [1:0]            in_tuser = '0;   // [1:0] mode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;       // [7:0] out_byte
  logic [4:0]            out_tuser;       // [0] byte_valid [3:1] status [4] truncated
  logic                  out_tlast;

  line_scoreboard sb = new;
  int    send_idle = 0;
  int    recv_stall = 0;
  string closure_kind = "none";

  logic [7:0] directed_bytes [20] = '{
    CH_DOT, CH_DOT, 8'h61, CH_LF, CH_DOT, CH_CR, 8'h61, CH_LF, 8'h62, CH_CR,
    CH_LF, CH_CR, CH_CR, CH_LF, 8'h00, 8'hFF, CH_LF, CH_DOT, 8'hFF, CH_LF
  };
  int unsigned phase_cap    [6] = '{1, 0, 2, 5, 8191, 4096};
  logic [31:0] phase_limit  [6] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    32'd100000, 32'd1048576, 32'hFFFF_FFFF};
  bit          phase_unst   [6] = '{0, 1, 1, 0, 1, 1};
  int          phase_sidle  [6] = '{0, 63, 0, 36, 0, 36};
  int          phase_rstall [6] = '{0, 0, 63, 36, 0, 36};

  dot_terminated_line_deframer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tuser, out_tlast);
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 25) return CH_DOT;
    if (r < 40) return CH_CR;
    if (r < 55) return CH_LF;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_item(mode_t m, logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= m;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(m, b);
  endtask

  // keeps the stream open: a closing item is replaced by a plain byte
  task automatic send_open(mode_t m, logic [7:0] b);
    if (sb.would_close(m, b)) send_item(MODE_DATA, 8'h78);
    else send_item(m, b);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(logic [31:0] cap, logic [31:0] limit, logic [31:0] unst);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_LINE_CAPACITY;
    cfg_wdata <= cap;
    @(posedge clk);
    sb.set_reg(REG_LINE_CAPACITY, cap);
    cfg_addr  <= REG_RESPONSE_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    sb.set_reg(REG_RESPONSE_LIMIT, limit);
    cfg_addr  <= REG_UNSTUFF_ENABLE;
    cfg_wdata <= unst;
    @(posedge clk);
    sb.set_reg(REG_UNSTUFF_ENABLE, unst);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int kind;
    int n;
    bit coin;
    logic [31:0] limit;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_bytes[i]) send_open(MODE_DATA, directed_bytes[i]);
    send_open(MODE_RSVD, 8'hFF);
    send_open(MODE_RSVD, 8'h00);

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_regs(phase_cap[p], phase_limit[p], phase_unst[p]);
      send_idle  = phase_sidle[p];
      recv_stall = phase_rstall[p];
      n = 0;
      while (n < 45) begin
        if ($urandom_range(99) < 5) begin
          send_open(MODE_RSVD, 8'($urandom_range(255)));
        end else begin
          send_open(MODE_DATA, pick_byte());
          n++;
        end
      end
    end

    // close the stream one way, then keep feeding the closed stream
    wait_drained();
    kind = $urandom_range(4);
    coin = $urandom_range(1);
    limit = 32'hFFFF_FFFF;
    if (kind == 4) limit = coin ? 32'd0 : 32'(sb.st.total + $urandom_range(3));
    write_regs((kind == 4 && $urandom_range(1)) ? 1 : 4096, limit, $urandom_range(1));
    send_idle  = 36;
    recv_stall = 36;
    case (kind)
      0: begin
        closure_kind = "terminator";
        send_item(MODE_DATA, CH_LF);
        send_item(MODE_DATA, CH_DOT);
        if (coin) send_item(MODE_DATA, CH_CR);
        send_item(MODE_DATA, CH_LF);
      end
      1: begin
        closure_kind = "end of stream at line start";
        send_item(MODE_DATA, CH_LF);
        send_item(MODE_END, 8'h00);
      end
      2: begin
        closure_kind = "end of stream mid-line";
        send_item(MODE_DATA, 8'h61);
        if (coin) send_item(MODE_DATA, CH_CR);
        send_item(MODE_END, 8'hFF);
      end
      3: begin
        closure_kind = "source failure mid-line";
        send_item(MODE_DATA, 8'h61);
        send_item(MODE_FAIL, 8'h00);
      end
      default: begin
        closure_kind = "ceiling cut";
        send_item(MODE_DATA, CH_DOT);
        send_item(MODE_DATA, CH_DOT);
        send_item(MODE_DATA, CH_CR);
        send_item(MODE_DATA, 8'h71);
        send_item(MODE_DATA, CH_CR);
        send_item(MODE_DATA, 8'h72);
      end
    endcase
    repeat (10) send_item(mode_t'($urandom_range(3)), 8'($urandom_range(255)));

    wait_drained();
    repeat (10) @(posedge clk);
    $display("%0d items accepted, %0d results checked, %0d mismatches",
             sb.items_seen, sb.results_seen, sb.mismatches);
    $display("six register settings and four idle patterns; stream closed by %s",
             closure_kind);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

### filelist.f
src/dtld_pkg.sv
src/dtld_front.sv
src/dtld_queue.sv
src/dtld_back.sv
src/dot_terminated_line_deframer_top.sv
bench/dot_terminated_line_deframer_top_tb.sv
